FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, held off by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/mng_pkg.sv
// ----------------------------------------------------------------------------
// mng_pkg
// Widths, constants, types and helpers of the NDC to geodetic mapper.
// ----------------------------------------------------------------------------
package mng_pkg;

    localparam int STEPS          = 24;
    localparam int ANGLE_BITS     = 16;
    localparam int TRIG_FRAC_BITS = 17;
    localparam int QF             = 30;
    localparam int TO_Q30_SH      = QF - TRIG_FRAC_BITS;
    localparam int CW             = 40;   // CORDIC x/y width, Q30
    localparam int ZW             = 34;   // CORDIC phase width
    localparam int TW             = 20;   // trig / vector component width
    localparam int IDXW           = 2;
    localparam int SHW            = 5;

    localparam logic signed [CW-1:0] GAIN         = 40'sd652032874;
    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;

    localparam logic [IDXW-1:0] REG_CENTER_LON = 2'd0;
    localparam logic [IDXW-1:0] REG_CENTER_LAT = 2'd1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic                 vec_mode;  // 1: drive y to zero, 0: drive z to zero
        logic [SHW-1:0]       shift;
        logic signed [ZW-1:0] arc;
    } cell_ctl_t;

    // arctan(2^-i) in 2^32-per-turn phase units
    function automatic logic signed [ZW-1:0] arc_at(input logic [SHW-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:    r = 34'sd536870912;
            5'd1:    r = 34'sd316933406;
            5'd2:    r = 34'sd167458907;
            5'd3:    r = 34'sd85004756;
            5'd4:    r = 34'sd42667331;
            5'd5:    r = 34'sd21354465;
            5'd6:    r = 34'sd10679838;
            5'd7:    r = 34'sd5340245;
            5'd8:    r = 34'sd2670163;
            5'd9:    r = 34'sd1335087;
            5'd10:   r = 34'sd667544;
            5'd11:   r = 34'sd333772;
            5'd12:   r = 34'sd166886;
            5'd13:   r = 34'sd83443;
            5'd14:   r = 34'sd41722;
            5'd15:   r = 34'sd20861;
            5'd16:   r = 34'sd10430;
            5'd17:   r = 34'sd5215;
            5'd18:   r = 34'sd2608;
            5'd19:   r = 34'sd1304;
            5'd20:   r = 34'sd652;
            5'd21:   r = 34'sd326;
            5'd22:   r = 34'sd163;
            5'd23:   r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q1.17 product, rounded half up
    function automatic logic signed [TW-1:0] mul_trig(input logic signed [TW-1:0] a,
                                                      input logic signed [TW-1:0] b);
        logic signed [2*TW:0] p;
        p = (2*TW+1)'(a) * (2*TW+1)'(b);
        p = p + ((2*TW+1)'(1) <<< (TRIG_FRAC_BITS - 1));
        return TW'(p >>> TRIG_FRAC_BITS);
    endfunction

    // 32-bit wrapped phase to binary angle, rounded half up, wrapping
    function automatic logic signed [ANGLE_BITS:0] phase_to_angle(
        input logic signed [ZW-1:0] z);
        logic signed [32:0] p;
        p = {z[31], z[31:0]};
        p = p + (33'sd1 <<< (32 - ANGLE_BITS - 1));
        return (ANGLE_BITS+1)'(p >>> (32 - ANGLE_BITS));
    endfunction

endpackage

FILE: rtl/mng_cordic_cell.sv
// ----------------------------------------------------------------------------
// mng_cordic_cell
// One CORDIC micro-rotation, rotation or vectoring, registered.
// ----------------------------------------------------------------------------
module mng_cordic_cell (
    input  logic                clk,
    input  mng_pkg::cell_ctl_t  ctl,
    input  mng_pkg::cordic_t    d_in,
    output mng_pkg::cordic_t    d_out
);

    logic signed [mng_pkg::CW-1:0] dx;
    logic signed [mng_pkg::CW-1:0] dy;
    logic                          up;
    mng_pkg::cordic_t              d_next;
    mng_pkg::cordic_t              d_reg;

    always_comb
    begin
        dx = d_in.y >>> ctl.shift;
        dy = d_in.x >>> ctl.shift;
        up = ctl.vec_mode ? d_in.y[mng_pkg::CW-1] : !d_in.z[mng_pkg::ZW-1];
        if (up)
        begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - ctl.arc;
        end
        else
        begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + ctl.arc;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign d_out = d_reg;

endmodule

FILE: rtl/map_ndc_to_geodetic.sv
// ----------------------------------------------------------------------------
// map_ndc_to_geodetic
// Inverse rotated-pole equirectangular lookup: NDC point to longitude/latitude.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock, busy is always low, and each result
// appears on done/longitude/latitude after passing three 24-cell CORDIC chains
// in series (sine/cosine, longitude atan2, latitude atan2) and ten register
// stages: input capture, rounding, the three multiply/sum stages, the capture
// ahead of each vectoring chain, both registers of the magnitude gain multiply
// and the result register. The first of these loads at the accept edge. The
// receiver cannot stall: done is a one-cycle strobe and the result must be
// taken then. Center longitude and latitude (binary angle, 32768 = pi) are
// written through the cfg port, which is always ready; write them only with
// no requests in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module map_ndc_to_geodetic (
    input  logic        clk,
    input  logic        rst_n,
    // request
    input  logic        start,
    output logic        busy,
    input  logic [15:0] ndc_x,
    input  logic [15:0] ndc_y,
    // result
    output logic        done,
    output logic [15:0] longitude,
    output logic [15:0] latitude,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [mng_pkg::IDXW-1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int S   = mng_pkg::STEPS;
    localparam int CW  = mng_pkg::CW;
    localparam int ZW  = mng_pkg::ZW;
    localparam int TW  = mng_pkg::TW;
    localparam int SH  = mng_pkg::TO_Q30_SH;
    localparam int AB  = mng_pkg::ANGLE_BITS;
    // pipeline taps, counted in register stages after the accept edge
    localparam int V_OUT = 3 * S + 8;   // last stage before the result register
    localparam int SPW   = 48;          // low partial product width
    localparam int SHI   = CW - 18;     // high slice width
    localparam int PHW   = SHI + 31;    // high partial product width
    localparam int SUMW  = PHW + 19;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [15:0] clon_reg, clat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clon_reg <= '0;
            clat_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mng_pkg::REG_CENTER_LON: clon_reg <= cfg_data;
                mng_pkg::REG_CENTER_LAT: clat_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid line through the whole pipe
    logic [V_OUT:0] vld_reg;
    logic           done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[V_OUT-1:0], accept};
            done_reg <= vld_reg[V_OUT];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: phases and quadrant fold for the four sine/cosine chains
    // order: center lon, center lat, local lon, local lat
    // ------------------------------------------------------------------------
    logic [31:0]        ph [4];
    mng_pkg::cordic_t   rot_next [4];
    logic [3:0]         flip_next;

    always_comb
    begin
        ph[0] = {clon_reg, 16'b0};
        ph[1] = {clat_reg, 16'b0};
        ph[2] = {ndc_x, 16'b0};
        ph[3] = {ndc_y[15], ndc_y, 15'b0};
        for (int j = 0; j < 4; j++)
        begin
            rot_next[j].x = mng_pkg::GAIN;
            rot_next[j].y = '0;
            rot_next[j].z = ZW'($signed(ph[j]));
            flip_next[j]  = 1'b0;
            if (rot_next[j].z > mng_pkg::QUARTER_TURN)
            begin
                rot_next[j].z = rot_next[j].z - mng_pkg::HALF_TURN;
                flip_next[j]  = 1'b1;
            end
            else if (rot_next[j].z < -mng_pkg::QUARTER_TURN)
            begin
                rot_next[j].z = rot_next[j].z + mng_pkg::HALF_TURN;
                flip_next[j]  = 1'b1;
            end
        end
    end

    mng_pkg::cordic_t rot_pipe [4][S+1];
    logic [3:0]       flip_reg [S+1];

    always_ff @(posedge clk)
    begin
        flip_reg[0] <= flip_next;
        for (int i = 0; i < S; i++)
        begin
            flip_reg[i+1] <= flip_reg[i];
        end
    end

    // Four rotation chains
    for (genvar j = 0; j < 4; j++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            rot_pipe[j][0] <= rot_next[j];
        end

        for (genvar i = 0; i < S; i++)
        begin : g_cell
            mng_pkg::cell_ctl_t ctl;
            assign ctl.vec_mode = 1'b0;
            assign ctl.shift    = mng_pkg::SHW'(i);
            assign ctl.arc      = mng_pkg::arc_at(mng_pkg::SHW'(i));
            mng_cordic_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .d_in  (rot_pipe[j][i]),
                .d_out (rot_pipe[j][i+1])
            );
        end
    end

    // ------------------------------------------------------------------------
    // Unfold and round to Q1.17
    // ------------------------------------------------------------------------
    logic signed [TW-1:0] sin_reg [4], cos_reg [4];

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 4; j++)
        begin
            logic signed [CW-1:0] cx, sy;
            cx = flip_reg[S][j] ? -rot_pipe[j][S].x : rot_pipe[j][S].x;
            sy = flip_reg[S][j] ? -rot_pipe[j][S].y : rot_pipe[j][S].y;
            cos_reg[j] <= TW'((cx + (CW'(1) <<< (SH - 1))) >>> SH);
            sin_reg[j] <= TW'((sy + (CW'(1) <<< (SH - 1))) >>> SH);
        end
    end

    // ------------------------------------------------------------------------
    // Rotation into the earth frame: three product/sum stages
    // ------------------------------------------------------------------------
    logic signed [TW-1:0] a_reg, b_reg, c_reg, p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [TW-1:0] slon_reg, clon1_reg, slat_reg, clat1_reg;
    logic signed [TW-1:0] t_reg [8];
    logic signed [TW-1:0] vx_reg, vy_reg, vz_reg;

    always_ff @(posedge clk)
    begin
        a_reg     <= mng_pkg::mul_trig(cos_reg[3], cos_reg[2]);
        b_reg     <= mng_pkg::mul_trig(cos_reg[3], sin_reg[2]);
        c_reg     <= sin_reg[3];
        p1_reg    <= mng_pkg::mul_trig(cos_reg[1], cos_reg[0]);
        p2_reg    <= mng_pkg::mul_trig(sin_reg[1], cos_reg[0]);
        p3_reg    <= mng_pkg::mul_trig(cos_reg[1], sin_reg[0]);
        p4_reg    <= mng_pkg::mul_trig(sin_reg[1], sin_reg[0]);
        slon_reg  <= sin_reg[0];
        clon1_reg <= cos_reg[0];
        slat_reg  <= sin_reg[1];
        clat1_reg <= cos_reg[1];

        t_reg[0] <= mng_pkg::mul_trig(p1_reg, a_reg);
        t_reg[1] <= mng_pkg::mul_trig(slon_reg, b_reg);
        t_reg[2] <= mng_pkg::mul_trig(p2_reg, c_reg);
        t_reg[3] <= mng_pkg::mul_trig(p3_reg, a_reg);
        t_reg[4] <= mng_pkg::mul_trig(clon1_reg, b_reg);
        t_reg[5] <= mng_pkg::mul_trig(p4_reg, c_reg);
        t_reg[6] <= mng_pkg::mul_trig(slat_reg, a_reg);
        t_reg[7] <= mng_pkg::mul_trig(clat1_reg, c_reg);

        vx_reg <= t_reg[0] - t_reg[1] - t_reg[2];
        vy_reg <= t_reg[3] + t_reg[4] - t_reg[5];
        vz_reg <= t_reg[6] + t_reg[7];
    end

    // ------------------------------------------------------------------------
    // Longitude: atan2(vy, vx) by vectoring
    // ------------------------------------------------------------------------
    mng_pkg::cordic_t     v1_next;
    logic signed [CW-1:0] vxq, vyq;

    always_comb
    begin
        vxq = CW'(vx_reg) <<< SH;
        vyq = CW'(vy_reg) <<< SH;
        if (vxq[CW-1])
        begin
            v1_next.x = -vxq;
            v1_next.y = -vyq;
            v1_next.z = mng_pkg::HALF_TURN;
        end
        else
        begin
            v1_next.x = vxq;
            v1_next.y = vyq;
            v1_next.z = '0;
        end
    end

    mng_pkg::cordic_t     v1_pipe [S+1];
    logic signed [TW-1:0] vz1_reg [S+1];
    logic                 zero1_reg [S+1];

    always_ff @(posedge clk)
    begin
        v1_pipe[0]   <= v1_next;
        vz1_reg[0]   <= vz_reg;
        zero1_reg[0] <= (vx_reg == '0) && (vy_reg == '0);
        for (int i = 0; i < S; i++)
        begin
            vz1_reg[i+1]   <= vz1_reg[i];
            zero1_reg[i+1] <= zero1_reg[i];
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_vec1
        mng_pkg::cell_ctl_t ctl;
        assign ctl.vec_mode = 1'b1;
        assign ctl.shift    = mng_pkg::SHW'(i);
        assign ctl.arc      = mng_pkg::arc_at(mng_pkg::SHW'(i));
        mng_cordic_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .d_in  (v1_pipe[i]),
            .d_out (v1_pipe[i+1])
        );
    end

    // Magnitude gain correction, split over two stages
    logic [SPW-1:0]        pp_lo_reg;
    logic signed [PHW-1:0] pp_hi_reg;
    logic signed [AB:0]    lonp_reg;
    logic signed [TW-1:0]  vzp_reg;
    logic                  zerop_reg;

    logic signed [CW-1:0]  rxy_reg;
    logic signed [AB:0]    lon_reg;
    logic signed [TW-1:0]  vzq_reg;

    always_ff @(posedge clk)
    begin
        pp_lo_reg <= SPW'(v1_pipe[S].x[17:0]) * SPW'(mng_pkg::GAIN[29:0]);
        pp_hi_reg <= PHW'($signed(v1_pipe[S].x[CW-1:18])) * PHW'(mng_pkg::GAIN);
        lonp_reg  <= mng_pkg::phase_to_angle(v1_pipe[S].z);
        vzp_reg   <= vz1_reg[S];
        zerop_reg <= zero1_reg[S];
    end

    always_ff @(posedge clk)
    begin
        logic signed [SUMW-1:0] sum;
        sum = (SUMW'(pp_hi_reg) <<< 18) + $signed(SUMW'(pp_lo_reg))
            + (SUMW'(1) <<< (mng_pkg::QF - 1));
        rxy_reg <= zerop_reg ? '0 : CW'(sum >>> mng_pkg::QF);
        lon_reg <= zerop_reg ? '0 : lonp_reg;
        vzq_reg <= vzp_reg;
    end

    // ------------------------------------------------------------------------
    // Latitude: atan2(vz, rxy) by vectoring
    // ------------------------------------------------------------------------
    mng_pkg::cordic_t     v2_next;
    logic signed [CW-1:0] vzl;

    always_comb
    begin
        vzl = CW'(vzq_reg) <<< SH;
        if (rxy_reg[CW-1])
        begin
            v2_next.x = -rxy_reg;
            v2_next.y = -vzl;
            v2_next.z = mng_pkg::HALF_TURN;
        end
        else
        begin
            v2_next.x = rxy_reg;
            v2_next.y = vzl;
            v2_next.z = '0;
        end
    end

    mng_pkg::cordic_t     v2_pipe [S+1];
    logic [15:0]          lon_line_reg [S+1];
    logic                 zero2_reg [S+1];

    always_ff @(posedge clk)
    begin
        v2_pipe[0]      <= v2_next;
        lon_line_reg[0] <= lon_reg[15:0];
        zero2_reg[0]    <= (rxy_reg == '0) && (vzq_reg == '0);
        for (int i = 0; i < S; i++)
        begin
            lon_line_reg[i+1] <= lon_line_reg[i];
            zero2_reg[i+1]    <= zero2_reg[i];
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_vec2
        mng_pkg::cell_ctl_t ctl;
        assign ctl.vec_mode = 1'b1;
        assign ctl.shift    = mng_pkg::SHW'(i);
        assign ctl.arc      = mng_pkg::arc_at(mng_pkg::SHW'(i));
        mng_cordic_cell u_cell (
            .clk   (clk),
            .ctl   (ctl),
            .d_in  (v2_pipe[i]),
            .d_out (v2_pipe[i+1])
        );
    end

    // ------------------------------------------------------------------------
    // Result register: latitude rounded and held to a quarter turn
    // ------------------------------------------------------------------------
    localparam logic signed [AB:0] QTR = (AB+1)'(1) <<< (AB - 2);

    logic signed [AB:0] lat_raw;
    logic signed [AB:0] lat_sat;
    logic [15:0]        lon_out_reg, lat_out_reg;

    always_comb
    begin
        lat_raw = mng_pkg::phase_to_angle(v2_pipe[S].z);
        lat_sat = lat_raw;
        if (lat_raw > QTR)
        begin
            lat_sat = QTR;
        end
        else if (lat_raw < -QTR)
        begin
            lat_sat = -QTR;
        end
    end

    always_ff @(posedge clk)
    begin
        lon_out_reg <= lon_line_reg[S];
        lat_out_reg <= zero2_reg[S] ? '0 : lat_sat[15:0];
    end

    assign done      = done_reg;
    assign longitude = lon_out_reg;
    assign latitude  = lat_out_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_enters, accept, vld_reg[0])
    `ASSERT_IMPLIES(a_lat_range, done,
        ($signed(latitude) <= 16'sd16384) && ($signed(latitude) >= -16'sd16384))
    `ASSERT_NEXT(a_done_tracks_pipe, vld_reg[V_OUT], done)

endmodule

FILE: verif/map_ndc_to_geodetic_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// map_ndc_to_geodetic_tb
// Drives NDC map points through the mapper under several map centers and
// checks every longitude/latitude against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module map_ndc_to_geodetic_tb;

    localparam int  N_RANDOM  = 1500;
    localparam int  DRAIN     = 100;
    localparam int  LIMIT     = 400000;

    // arctan(2^-i) in 2^32-per-turn phase units
    localparam longint ATAN_PH [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};
    localparam longint GAIN_Q30 = 652032874;
    localparam longint HALF_PH  = 64'sd2147483648;
    localparam longint QUART_PH = 64'sd1073741824;

    typedef struct {
        logic [15:0] lon;
        logic [15:0] lat;
    } geo_t;

    // Scoreboard: holds the map center and the geodetic points still owed.
    class geo_scoreboard;
        logic [15:0] ctr_lon;
        logic [15:0] ctr_lat;
        geo_t        owed[$];
        int          errors;
        int          n_req;
        int          n_res;

        function new();
            ctr_lon = '0;
            ctr_lat = '0;
            errors  = 0;
            n_req   = 0;
            n_res   = 0;
        endfunction

        function longint rnd_sh(longint v, int n);
            return (v + (64'sd1 <<< (n - 1))) >>> n;
        endfunction

        function longint tmul(longint a, longint b);
            return rnd_sh(a * b, mng_pkg::TRIG_FRAC_BITS);
        endfunction

        function longint ph_signed(logic [31:0] p);
            return longint'($signed(p));
        endfunction

        // rotation-mode CORDIC, result in Q1.17
        function void sincos(logic [31:0] ph, output longint s, output longint c);
            longint z, x, y, dx, dy;
            bit flip;
            z = ph_signed(ph);
            x = GAIN_Q30;
            y = 0;
            flip = 0;
            if (z > QUART_PH)
            begin
                z -= HALF_PH;
                flip = 1;
            end
            else if (z < -QUART_PH)
            begin
                z += HALF_PH;
                flip = 1;
            end
            for (int i = 0; i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= ATAN_PH[i];
                end
                else
                begin
                    x += dx; y -= dy; z += ATAN_PH[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = rnd_sh(x, mng_pkg::QF - mng_pkg::TRIG_FRAC_BITS);
            s = rnd_sh(y, mng_pkg::QF - mng_pkg::TRIG_FRAC_BITS);
        endfunction

        // vectoring-mode CORDIC: phase of (x,y) plus gain-corrected magnitude
        function logic [31:0] vec_phase(longint x, longint y, output longint mag);
            longint z, dx, dy;
            z = 0;
            if (x < 0)
            begin
                x = -x; y = -y; z = HALF_PH;
            end
            for (int i = 0; i < 24; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y < 0)
                begin
                    x -= dx; y += dy; z -= ATAN_PH[i];
                end
                else
                begin
                    x += dx; y -= dy; z += ATAN_PH[i];
                end
            end
            mag = rnd_sh(x * GAIN_Q30, 30);
            return z[31:0];
        endfunction

        function longint ph_to_ang(logic [31:0] p);
            return rnd_sh(ph_signed(p), 32 - mng_pkg::ANGLE_BITS);
        endfunction

        function void write_reg(logic [mng_pkg::IDXW-1:0] idx, logic [15:0] val);
            if (idx == mng_pkg::REG_CENTER_LON)
                ctr_lon = val;
            else if (idx == mng_pkg::REG_CENTER_LAT)
                ctr_lat = val;
        endfunction

        // accepted request: predict the point it maps to
        function void note_request(logic [15:0] nx, logic [15:0] ny);
            logic [31:0] lon_ph, lat_ph, clon_ph, clat_ph;
            longint slon, clon, slat, clat, slo, clo, sla, cla;
            longint a, b, c, vx, vy, vz, rxy, unused, lon, lat;
            geo_t g;
            lon_ph  = {nx, 16'h0};
            lat_ph  = 32'(longint'($signed(ny)) * 32768);
            clon_ph = {ctr_lon, 16'h0};
            clat_ph = {ctr_lat, 16'h0};
            sincos(clon_ph, slon, clon);
            sincos(clat_ph, slat, clat);
            sincos(lon_ph, slo, clo);
            sincos(lat_ph, sla, cla);
            a = tmul(cla, clo);
            b = tmul(cla, slo);
            c = sla;
            vx = tmul(tmul(clat, clon), a) - tmul(slon, b) - tmul(tmul(slat, clon), c);
            vy = tmul(tmul(clat, slon), a) + tmul(clon, b) - tmul(tmul(slat, slon), c);
            vz = tmul(slat, a) + tmul(clat, c);
            vx = vx <<< mng_pkg::TO_Q30_SH;
            vy = vy <<< mng_pkg::TO_Q30_SH;
            vz = vz <<< mng_pkg::TO_Q30_SH;
            // on the polar axis longitude is defined as zero
            if (vx == 0 && vy == 0)
            begin
                lon = 0;
                rxy = 0;
            end
            else
                lon = ph_to_ang(vec_phase(vx, vy, rxy));
            if (rxy == 0 && vz == 0)
                lat = 0;
            else
                lat = ph_to_ang(vec_phase(rxy, vz, unused));
            if (lat > 16384)  lat = 16384;
            if (lat < -16384) lat = -16384;
            g.lon = lon[15:0];
            g.lat = lat[15:0];
            owed.push_back(g);
            n_req++;
        endfunction

        function void check_result(logic [15:0] lon, logic [15:0] lat);
            geo_t g;
            n_res++;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result lon=%0d lat=%0d", $time,
                         $signed(lon), $signed(lat));
                errors++;
                return;
            end
            g = owed.pop_front();
            if (lon !== g.lon)
            begin
                $display("%0t: longitude expected %0d actual %0d", $time,
                         $signed(g.lon), $signed(lon));
                errors++;
            end
            if (lat !== g.lat)
            begin
                $display("%0t: latitude expected %0d actual %0d", $time,
                         $signed(g.lat), $signed(lat));
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [15:0]                 ndc_x;
    logic [15:0]                 ndc_y;
    logic                        done;
    logic [15:0]                 longitude;
    logic [15:0]                 latitude;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [mng_pkg::IDXW-1:0]    cfg_index;
    logic [15:0]                 cfg_data;

    logic              busy_seen;      // busy as it will be at the next rising edge
    logic              cfg_ready_seen;
    int                cycles;
    int                n_cfg;
    geo_scoreboard     sb;

    map_ndc_to_geodetic dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .ndc_x     (ndc_x),
        .ndc_y     (ndc_y),
        .done      (done),
        .longitude (longitude),
        .latitude  (latitude),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Outputs change only just after a rising edge, so the value at the
    // falling edge is the value the next rising edge will see.
    always @(negedge clk)
    begin
        busy_seen      <= busy;
        cfg_ready_seen <= cfg_ready;
    end

    // Monitor: reads pre-edge values of all handshakes.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
                n_cfg++;
            end
            if (start && !busy)
                sb.note_request(ndc_x, ndc_y);
            if (done)
                sb.check_result(longitude, latitude);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One request; start is left high so a burst runs back to back.
    task automatic send_point(logic [15:0] x, logic [15:0] y);
        start <= 1'b1;
        ndc_x <= x;
        ndc_y <= y;
        @(posedge clk);
        while (busy_seen)
            @(posedge clk);
    endtask

    task automatic pause_sender(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait until every owed result has come, then let the pipe settle.
    task automatic drain_results();
        start <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_cfg(logic [mng_pkg::IDXW-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready_seen)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_center(logic [15:0] lon, logic [15:0] lat);
        write_cfg(mng_pkg::REG_CENTER_LON, lon);
        write_cfg(mng_pkg::REG_CENTER_LAT, lat);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random bursts with random gaps; some stretches run with no gaps.
    task automatic random_traffic(int n);
        int left;
        int burst;
        bit steady;
        left = n;
        while (left > 0)
        begin
            burst  = $urandom_range(1, 40);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                send_point(pick_coord(), pick_coord());
                left--;
            end
            if (!steady)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    // Directed points: field extremes, map origin, poles, and the seam at pi.
    task automatic directed_points();
        logic [15:0] edges [7];
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff,
                  16'h4000, 16'hc000};
        foreach (edges[i])
            send_point(edges[i], 16'h0000);
        foreach (edges[i])
            send_point(16'h0000, edges[i]);
        send_point(16'h8000, 16'h8000);
        send_point(16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h7fff);
        send_point(16'h7fff, 16'h8000);
        send_point(16'h5555, 16'haaaa);
        send_point(16'haaaa, 16'h5555);
    endtask

    initial
    begin
        // centers: origin, both extremes, beyond the poles, then random ones
        logic [15:0] c_lon [8];
        logic [15:0] c_lat [8];
        c_lon = '{16'h0000, 16'h7fff, 16'h8000, 16'h1234, 16'hc000,
                  16'h0000, 16'h0000, 16'h0000};
        c_lat = '{16'h0000, 16'h4000, 16'hc000, 16'h7fff, 16'h8000,
                  16'h2000, 16'h0000, 16'h0000};
        sb         = new();
        cycles     = 0;
        n_cfg      = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        ndc_x      = '0;
        ndc_y      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = mng_pkg::REG_CENTER_LON;
        cfg_data   = '0;
        busy_seen      = 1'b1;
        cfg_ready_seen = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset center first, directed set untouched by any write
        directed_points();
        drain_results();

        c_lon[6] = 16'($urandom);
        c_lat[6] = 16'($urandom_range(0, 32768) - 16384);
        c_lon[7] = 16'($urandom);
        c_lat[7] = 16'($urandom);
        for (int ph = 0; ph < 8; ph++)
        begin
            set_center(c_lon[ph], c_lat[ph]);
            // indexes past the register list must be ignored
            if (ph == 3)
            begin
                write_cfg(mng_pkg::IDXW'(2), 16'($urandom));
                write_cfg(mng_pkg::IDXW'(3), 16'($urandom));
            end
            if (ph < 3)
                directed_points();
            random_traffic(N_RANDOM / 8);
            // hold off once mid-phase until the pipe is empty
            if (ph == 4)
            begin
                drain_results();
                random_traffic(20);
            end
            drain_results();
        end

        $display("covered %0d requests, %0d results, %0d register writes over 8 centers",
                 sb.n_req, sb.n_res, n_cfg);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mng_pkg.sv
rtl/mng_cordic_cell.sv
rtl/map_ndc_to_geodetic.sv
verif/map_ndc_to_geodetic_tb.sv
